[src/ttss_pkg.sv]
// Shared constants, types and codes for the timed tone step sequencer.
package ttss_pkg;

   // Table geometry
   localparam int MAX_STEPS = 6;
   localparam int IDX_W     = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int COUNT_W   = $clog2(MAX_STEPS + 1);

   // Item queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int TIME_W = 32;
   localparam int HZ_W   = 16;
   localparam int DUR_W  = 16;
   localparam int GAP_W  = 16;

   // Input item kinds as carried on req_type
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef enum logic {
      OP_LOAD,
      OP_TICK
   } op_type;

   // Classified item as held in the queue
   typedef struct packed {
      op_type              op;
      logic [TIME_W-1:0]   now_ms;
      logic                first_step;
      logic [HZ_W-1:0]     tone_hz;
      logic [DUR_W-1:0]    tone_ms;
      logic [GAP_W-1:0]    gap_ms;
   } item_type;

   // One stored step
   typedef struct packed {
      logic [HZ_W-1:0]     hz;
      logic [DUR_W-1:0]    dur;
      logic [TIME_W-1:0]   at;
   } step_type;

   // Queue to back handshake
   typedef struct packed {
      logic     valid;
      item_type item;
   } q_head_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } back_state_type;

endpackage

[src/ttss_front.sv]
// Front end: decodes input items and drops them while the block is disabled.
module ttss_front
   import ttss_pkg::*;
(
   input  logic               enable,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [TIME_W-1:0]  req_now_ms,
   input  logic               req_first_step,
   input  logic [HZ_W-1:0]    req_tone_hz,
   input  logic [DUR_W-1:0]   req_tone_ms,
   input  logic [GAP_W-1:0]   req_gap_ms,
   input  logic               q_full,
   output logic               q_push,
   output item_type           q_item
);

   always_comb begin
      q_item.op         = (req_type == REQ_TICK) ? OP_TICK : OP_LOAD;
      q_item.now_ms     = req_now_ms;
      q_item.first_step = req_first_step;
      q_item.tone_hz    = req_tone_hz;
      q_item.tone_ms    = req_tone_ms;
      q_item.gap_ms     = req_gap_ms;
   end

   assign req_stall = q_full;
   // disabled: item is taken and dropped, nothing to do for it
   assign q_push    = req_valid && !q_full && enable;

endmodule

[src/ttss_queue.sv]
// Short item queue decoupling the front end from the back end.
module ttss_queue
   import ttss_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  item_type   push_item,
   output logic       full,
   input  logic       pop,
   output q_head_type head
);

   item_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] r;
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + QPTR_W'(1);
      end
      return r;
   endfunction

   assign full = (cnt_ff == QCNT_W'(QUEUE_DEPTH));

   always_comb begin
      head.valid = (cnt_ff != '0);
      head.item  = mem_ff[rd_ptr_ff];
   end

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[src/ttss_back.sv]
// Back end: step table, load execution and tick scan with output register.
module ttss_back
   import ttss_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  q_head_type        head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [HZ_W-1:0]   rsp_out_hz,
   output logic [DUR_W-1:0]  rsp_out_ms,
   output logic              rsp_last_of_run
);

   back_state_type       state_ff, state_in;
   step_type             table_ff [MAX_STEPS];
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [COUNT_W-1:0]   next_ff, next_in;
   logic [TIME_W-1:0]    run_start_ff, run_start_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic                 pend_vld_ff, pend_vld_in;
   step_type             pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [HZ_W-1:0]      rsp_hz_ff, rsp_hz_in;
   logic [DUR_W-1:0]     rsp_ms_ff, rsp_ms_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_idx;
   step_type             wr_step;

   step_type             cur;
   logic [TIME_W-1:0]    diff;
   logic                 hit;
   logic                 out_free;
   logic [COUNT_W-1:0]   base_count;
   logic [TIME_W-1:0]    base_start;

   assign cur      = table_ff[next_ff[IDX_W-1:0]];
   assign diff     = now_ff - cur.at;
   assign hit      = (next_ff < count_ff) && !diff[TIME_W-1];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      next_in      = next_ff;
      run_start_in = run_start_ff;
      now_in       = now_ff;
      pend_vld_in  = pend_vld_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hz_in    = rsp_hz_ff;
      rsp_ms_in    = rsp_ms_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_idx       = '0;
      wr_step      = '0;
      base_count   = head.item.first_step ? '0 : count_ff;
      base_start   = head.item.first_step ? head.item.now_ms : run_start_ff;

      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.item.op == OP_LOAD) begin
                  if (head.item.first_step) begin
                     next_in = '0;
                  end
                  count_in     = base_count;
                  run_start_in = base_start;
                  if (base_count < COUNT_W'(MAX_STEPS)) begin
                     wr_en        = 1'b1;
                     wr_idx       = base_count[IDX_W-1:0];
                     wr_step.hz   = head.item.tone_hz;
                     wr_step.dur  = head.item.tone_ms;
                     wr_step.at   = base_start;
                     count_in     = base_count + COUNT_W'(1);
                     run_start_in = base_start + TIME_W'(head.item.gap_ms);
                  end
               end else begin
                  now_in      = head.item.now_ms;
                  pend_vld_in = 1'b0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // a held tone goes out only once we know whether another follows
            if (!pend_vld_ff || out_free) begin
               if (hit) begin
                  if (pend_vld_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_hz_in    = pend_ff.hz;
                     rsp_ms_in    = pend_ff.dur;
                     rsp_last_in  = 1'b0;
                  end
                  pend_in     = cur;
                  pend_vld_in = 1'b1;
                  next_in     = next_ff + COUNT_W'(1);
               end else begin
                  if (pend_vld_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_hz_in    = pend_ff.hz;
                     rsp_ms_in    = pend_ff.dur;
                     rsp_last_in  = 1'b1;
                  end
                  pend_vld_in = 1'b0;
                  state_in    = ST_IDLE;
                  if (next_ff >= count_ff) begin
                     count_in = '0;
                     next_in  = '0;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (clear) begin
         count_in = '0;
         next_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         next_ff      <= '0;
         run_start_ff <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_ff      <= next_in;
         run_start_ff <= run_start_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      pend_ff     <= pend_in;
      rsp_hz_ff   <= rsp_hz_in;
      rsp_ms_ff   <= rsp_ms_in;
      rsp_last_ff <= rsp_last_in;
      if (wr_en) begin
         table_ff[wr_idx] <= wr_step;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_hz      = rsp_hz_ff;
   assign rsp_out_ms      = rsp_ms_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

[src/timed_tone_step_sequencer_core.sv]
// Top level of the timed tone step sequencer: front end, item queue, back end.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  req     | in  | req_valid/req_stall  | req_type, now_ms, first_step, tone_hz,
//          |     |                      | tone_ms, gap_ms
//  rsp     | out | rsp_valid/rsp_stall  | out_hz, out_ms, last_of_run
//  csr     | in  | csr_valid/csr_ready  | enable
//
// A load item is executed in the idle state; a tick starts a tone scan
// of the table, up to six steps, one table entry per cycle, held up
// whenever the rsp side stalls.
// A two-item queue lets req items be taken while the back end is busy.
// Reset clears control state only; step table contents are never read unwritten.
// csr_ready is always high; writes are expected only while the block is idle.
module timed_tone_step_sequencer_core
   import ttss_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [TIME_W-1:0]  req_now_ms,
   input  logic               req_first_step,
   input  logic [HZ_W-1:0]    req_tone_hz,
   input  logic [DUR_W-1:0]   req_tone_ms,
   input  logic [GAP_W-1:0]   req_gap_ms,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [HZ_W-1:0]    rsp_out_hz,
   output logic [DUR_W-1:0]   rsp_out_ms,
   output logic               rsp_last_of_run,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_enable
);

   logic       enable_ff, enable_in;
   logic       csr_wr;
   logic       clear;
   logic       q_full;
   logic       q_push;
   item_type   q_item;
   logic       q_pop;
   q_head_type q_head;

   // Enable register; writing zero empties the table
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign enable_in = csr_wr ? csr_enable : enable_ff;
   assign clear     = csr_wr && !csr_enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else begin
         enable_ff <= enable_in;
      end
   end

   ttss_front u_front (
      .enable         (enable_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_now_ms     (req_now_ms),
      .req_first_step (req_first_step),
      .req_tone_hz    (req_tone_hz),
      .req_tone_ms    (req_tone_ms),
      .req_gap_ms     (req_gap_ms),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_item         (q_item)
   );

   ttss_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head)
   );

   ttss_back u_back (
      .clock           (clock),
      .reset           (reset),
      .clear           (clear),
      .head            (q_head),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_hz      (rsp_out_hz),
      .rsp_out_ms      (rsp_out_ms),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

[test/timed_tone_step_sequencer_core_test.sv]
// Self-checking testbench for the timed tone step sequencer core.
module timed_tone_step_sequencer_core_test;
   import ttss_pkg::*;

   // The two-item queue can hold loads still in flight after the last tone has come out.
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT   = 150000;

   typedef struct {
      logic [HZ_W-1:0]  hz;
      logic [DUR_W-1:0] ms;
      logic             last;
   } tone_type;

   // One directed stimulus row; typed_n < 0 leaves the expectation to the predictor
   typedef struct {
      op_type            op;
      logic [TIME_W-1:0] now;
      logic              first;
      logic [HZ_W-1:0]   hz;
      logic [DUR_W-1:0]  ms;
      logic [GAP_W-1:0]  gap;
      int                typed_n;
      logic [HZ_W-1:0]   typed_hz;
      logic [DUR_W-1:0]  typed_ms;
   } tone_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_type = REQ_LOAD;
   logic [TIME_W-1:0] req_now_ms = '0;
   logic              req_first_step = 1'b0;
   logic [HZ_W-1:0]   req_tone_hz = '0;
   logic [DUR_W-1:0]  req_tone_ms = '0;
   logic [GAP_W-1:0]  req_gap_ms = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [HZ_W-1:0]   rsp_out_hz;
   logic [DUR_W-1:0]  rsp_out_ms;
   logic              rsp_last_of_run;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_enable = 1'b1;

   timed_tone_step_sequencer_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_now_ms      (req_now_ms),
      .req_first_step  (req_first_step),
      .req_tone_hz     (req_tone_hz),
      .req_tone_ms     (req_tone_ms),
      .req_gap_ms      (req_gap_ms),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_hz      (rsp_out_hz),
      .rsp_out_ms      (rsp_out_ms),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_enable      (csr_enable)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the step table and its pointers
   logic [HZ_W-1:0]   shadow_hz [MAX_STEPS];
   logic [DUR_W-1:0]  shadow_ms [MAX_STEPS];
   logic [TIME_W-1:0] shadow_at [MAX_STEPS];
   int                steps_held = 0;
   int                steps_played = 0;
   logic [TIME_W-1:0] next_start = '0;
   logic              play_enabled = 1'b1;

   tone_type     expected_tones [$];
   tone_type     fresh_tones [$];
   tone_row_type directed_rows [$];
   int           mismatch_count = 0;
   int           items_sent = 0;
   int           cycle_count = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;

   // Works out the tones one accepted item releases, into fresh_tones
   function automatic void advance_sequencer(input op_type op, input logic [TIME_W-1:0] now,
                                             input logic first, input logic [HZ_W-1:0] hz,
                                             input logic [DUR_W-1:0] ms,
                                             input logic [GAP_W-1:0] gap);
      logic [TIME_W-1:0] lag;
      tone_type          t;
      fresh_tones.delete();
      if (!play_enabled)
         return;
      if (op == OP_LOAD) begin
         if (first) begin
            steps_held   = 0;
            steps_played = 0;
            next_start   = now;
         end
         // a full table drops the step and leaves the running start alone
         if (steps_held < MAX_STEPS) begin
            shadow_hz[steps_held] = hz;
            shadow_ms[steps_held] = ms;
            shadow_at[steps_held] = next_start;
            steps_held++;
            next_start = next_start + {{(TIME_W-GAP_W){1'b0}}, gap};
         end
         return;
      end
      while (steps_played < steps_held) begin
         // wrap-safe: due when the signed difference is not negative
         lag = now - shadow_at[steps_played];
         if (lag[TIME_W-1])
            break;
         t.hz   = shadow_hz[steps_played];
         t.ms   = shadow_ms[steps_played];
         t.last = 1'b0;
         fresh_tones.push_back(t);
         steps_played++;
      end
      if (fresh_tones.size() > 0) begin
         t = fresh_tones.pop_back();
         t.last = 1'b1;
         fresh_tones.push_back(t);
      end
      if (steps_played >= steps_held) begin
         steps_held   = 0;
         steps_played = 0;
      end
   endfunction

   // Presents one item, waits for it to be taken, then books its tones
   task automatic send_item(input op_type op, input logic [TIME_W-1:0] now,
                            input logic first, input logic [HZ_W-1:0] hz,
                            input logic [DUR_W-1:0] ms, input logic [GAP_W-1:0] gap,
                            input int typed_n = -1, input logic [HZ_W-1:0] typed_hz = '0,
                            input logic [DUR_W-1:0] typed_ms = '0);
      tone_type t;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= op;
      req_now_ms     <= now;
      req_first_step <= first;
      req_tone_hz    <= hz;
      req_tone_ms    <= ms;
      req_gap_ms     <= gap;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
      advance_sequencer(op, now, first, hz, ms, gap);
      if (typed_n < 0) begin
         foreach (fresh_tones[i])
            expected_tones.push_back(fresh_tones[i]);
      end else if (typed_n > 0) begin
         t.hz   = typed_hz;
         t.ms   = typed_ms;
         t.last = 1'b1;
         expected_tones.push_back(t);
      end
   endtask

   // Holds the sender off until every tone is out and the back end has gone quiet
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (expected_tones.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_enable(input logic value);
      csr_valid  <= 1'b1;
      csr_enable <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid    <= 1'b0;
      play_enabled = value;
      if (!value) begin
         steps_held   = 0;
         steps_played = 0;
      end
   endtask

   // Well-formed tune: a first load, more loads, then ticks around each start time
   task automatic play_tune();
      logic [TIME_W-1:0] base;
      logic [TIME_W-1:0] start;
      logic [TIME_W-1:0] starts [8];
      logic [GAP_W-1:0]  gap;
      int                n;
      base  = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 300) : $urandom();
      n     = $urandom_range(1, MAX_STEPS + 1);
      start = base;
      for (int k = 0; k < n; k++) begin
         gap = ($urandom_range(0, 7) == 0) ? GAP_W'($urandom()) : GAP_W'($urandom_range(0, 40));
         starts[k] = start;
         send_item(OP_LOAD, (k == 0) ? base : $urandom(), k == 0, HZ_W'($urandom()),
                   DUR_W'($urandom()), gap);
         start = start + {{(TIME_W-GAP_W){1'b0}}, gap};
      end
      for (int k = 0; k < n && k < MAX_STEPS; k++) begin
         send_item(OP_TICK, starts[k] + TIME_W'($urandom_range(0, 6)) - 32'd3,
                   1'($urandom_range(0, 1)), HZ_W'($urandom()), DUR_W'($urandom()),
                   GAP_W'($urandom()));
         // now and then a step is appended while the tune is still playing
         if ($urandom_range(0, 5) == 0)
            send_item(OP_LOAD, $urandom(), 1'b0, HZ_W'($urandom()), DUR_W'($urandom()),
                      GAP_W'($urandom_range(0, 20)));
      end
      if ($urandom_range(0, 1) == 0)
         send_item(OP_TICK, start + 32'd100, 1'b0, '0, '0, '0);
   endtask

   task automatic add_row(input op_type op, input logic [TIME_W-1:0] now, input logic first,
                          input logic [HZ_W-1:0] hz, input logic [DUR_W-1:0] ms,
                          input logic [GAP_W-1:0] gap, input int typed_n,
                          input logic [HZ_W-1:0] typed_hz, input logic [DUR_W-1:0] typed_ms);
      tone_row_type r;
      r = '{op, now, first, hz, ms, gap, typed_n, typed_hz, typed_ms};
      directed_rows.push_back(r);
   endtask

   // Receiver back-pressure, redrawn every cycle
   always @(posedge clock)
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);

   always @(posedge clock) begin : tone_check
      tone_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tones.size() == 0) begin
            $error("tone with nothing expected: hz=%h ms=%h last=%b",
                   rsp_out_hz, rsp_out_ms, rsp_last_of_run);
            mismatch_count++;
         end else begin
            want = expected_tones.pop_front();
            if (rsp_out_hz !== want.hz) begin
               $error("out_hz: expected %h, got %h", want.hz, rsp_out_hz);
               mismatch_count++;
            end
            if (rsp_out_ms !== want.ms) begin
               $error("out_ms: expected %h, got %h", want.ms, rsp_out_ms);
               mismatch_count++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run: expected %b, got %b", want.last, rsp_last_of_run);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int idle_plan [6]   = '{0, 1, 2, 2, 3, 0};
      int enable_plan [6] = '{1, 1, 0, 1, 1, 1};
      int length_plan [6] = '{25, 25, 10, 25, 25, 25};
      int phase_end;
      int pick;

      // Directed table. Starts with an empty table and running start at zero.
      add_row(OP_TICK, 32'h0000_0000, 1'b0, 16'h0000, 16'h0000, 16'h0000, 0, '0, '0);
      add_row(OP_LOAD, 32'h0000_0000, 1'b0, 16'hFFFF, 16'hFFFF, 16'h0000, 0, '0, '0);
      add_row(OP_TICK, 32'h0000_0000, 1'b0, 16'h0000, 16'h0000, 16'h0000,
              1, 16'hFFFF, 16'hFFFF);
      // restart just short of the wrap, with the largest gap
      add_row(OP_LOAD, 32'hFFFF_FFF0, 1'b1, 16'h0000, 16'h0000, 16'hFFFF, 0, '0, '0);
      add_row(OP_LOAD, 32'h0000_0000, 1'b0, 16'h1234, 16'h0010, 16'h0001, 0, '0, '0);
      add_row(OP_TICK, 32'hFFFF_FFEF, 1'b0, 16'h0000, 16'h0000, 16'h0000, 0, '0, '0);
      add_row(OP_TICK, 32'hFFFF_FFF0, 1'b0, 16'h0000, 16'h0000, 16'h0000,
              1, 16'h0000, 16'h0000);
      add_row(OP_TICK, 32'h0000_FFEF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              1, 16'h1234, 16'h0010);
      // table emptied: plain loads refill from index 0 with the kept start time
      add_row(OP_LOAD, 32'hDEAD_BEEF, 1'b0, 16'hA5A5, 16'h5A5A, 16'h0000, 0, '0, '0);
      add_row(OP_LOAD, 32'h0000_0000, 1'b0, 16'h5A5A, 16'hA5A5, 16'h0001, -1, '0, '0);
      add_row(OP_LOAD, 32'h0000_0000, 1'b0, 16'h0F0F, 16'hF0F0, 16'h0002, -1, '0, '0);
      add_row(OP_LOAD, 32'h0000_0000, 1'b0, 16'hF0F0, 16'h0F0F, 16'h0003, -1, '0, '0);
      add_row(OP_LOAD, 32'h0000_0000, 1'b0, 16'h8001, 16'h7FFE, 16'h0004, -1, '0, '0);
      add_row(OP_LOAD, 32'h0000_0000, 1'b0, 16'h7FFE, 16'h8001, 16'h0005, -1, '0, '0);
      // seventh load finds the table full
      add_row(OP_LOAD, 32'h0000_0000, 1'b0, 16'h7777, 16'h7777, 16'h0777, 0, '0, '0);
      // just under half the clock range ahead of the first start: all six are due
      add_row(OP_TICK, 32'h8000_FFEF, 1'b0, 16'h0000, 16'h0000, 16'h0000, -1, '0, '0);
      add_row(OP_LOAD, 32'h0000_0064, 1'b1, 16'h0100, 16'h0200, 16'h000A, 0, '0, '0);
      add_row(OP_LOAD, 32'h0000_0000, 1'b0, 16'h0101, 16'h0201, 16'h000A, 0, '0, '0);
      add_row(OP_TICK, 32'h0000_0064, 1'b0, 16'h0000, 16'h0000, 16'h0000,
              1, 16'h0100, 16'h0200);
      // append while the second step is still pending
      add_row(OP_LOAD, 32'h0000_0000, 1'b0, 16'h0102, 16'h0202, 16'h0000, 0, '0, '0);
      // exactly half the range away counts as not yet reached
      add_row(OP_TICK, 32'h8000_006E, 1'b0, 16'h0000, 16'h0000, 16'h0000, 0, '0, '0);
      add_row(OP_TICK, 32'h0000_0078, 1'b0, 16'h0000, 16'h0000, 16'h0000, -1, '0, '0);
      add_row(OP_TICK, 32'hFFFF_FFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000, 0, '0, '0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].op, directed_rows[i].now, directed_rows[i].first,
                   directed_rows[i].hz, directed_rows[i].ms, directed_rows[i].gap,
                   directed_rows[i].typed_n, directed_rows[i].typed_hz,
                   directed_rows[i].typed_ms);

      // Random phases: each one drains, sets the idling mix and rewrites enable
      for (int p = 0; p < 6; p++) begin
         wait_for_idle();
         send_idle_pct  = (idle_plan[p] == 1) ? 58 : (idle_plan[p] == 3) ? 16 : 0;
         recv_stall_pct = (idle_plan[p] == 2) ? 58 : (idle_plan[p] == 3) ? 16 : 0;
         write_enable(enable_plan[p] != 0);
         phase_end = items_sent + length_plan[p];
         while (items_sent < phase_end) begin
            pick = $urandom_range(0, 9);
            if (pick < 8)
               play_tune();
            else if (pick == 8)
               send_item(op_type'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)),
                         HZ_W'($urandom()), DUR_W'($urandom()), GAP_W'($urandom()));
            else begin
               // broken tune: plain load with no restart, then a tick at a random time
               send_item(OP_LOAD, $urandom(), 1'b0, HZ_W'($urandom()), DUR_W'($urandom()),
                         GAP_W'($urandom()));
               send_item(OP_TICK, $urandom(), 1'b0, '0, '0, '0);
            end
         end
      end

      wait_for_idle();
      if (mismatch_count == 0 && expected_tones.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
